[sv/gpd_pkg.sv]
// gpd_pkg: shared constants, status codes and structs for the gamepad packet deframer
// no dependencies; compiled first
`default_nettype none

package gpd_pkg;

  // framing constants
  localparam logic [7:0] HDR_BYTE  = 8'hAA;
  localparam logic [7:0] END_BYTE  = 8'hBB;
  localparam logic [7:0] SALT_BYTE = 8'h55;
  localparam logic [7:0] AXIS_BIAS = 8'd128;
  localparam int         PKT_LEN   = 12;
  localparam int         POS_W     = $clog2(PKT_LEN);

  // packet slots of interest
  localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SUM   = POS_W'(PKT_LEN - 2);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PKT_LEN - 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PKT_LEN);

  // result status codes
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_BAD_END = 2'd1,
    ST_BAD_SUM = 2'd2
  } status_t;

  // completed packet handed from the collector to the checker
  typedef struct packed {
    logic            fire;       // last byte accepted this cycle
    logic [7:0]      sum;        // xor of bytes 0..9
    logic [7:0]      check_byte; // byte 10
    logic [7:0]      end_byte;   // byte 11
    logic [8:0][7:0] data;       // bytes 1..9, data[0] is byte 1
  } pkt_done_t;

  // flow control from collector to top
  typedef struct packed {
    logic last_slot;             // next accepted byte completes a packet
  } coll_stat_t;

endpackage

`default_nettype wire

[sv/gpd_ifs.sv]
// gpd_byte_if and gpd_result_if: valid/ready channels for bytes and decoded packets
// depends on gpd_pkg
`default_nettype none

interface gpd_byte_if
  import gpd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gpd_result_if
  import gpd_pkg::*;
;
  logic              valid;
  logic              ready;
  status_t           status;
  logic signed [7:0] axis_one;
  logic signed [7:0] axis_two;
  logic signed [7:0] axis_three;
  logic signed [7:0] axis_four;
  logic [15:0]       button_mask;
  logic [7:0]        analog_a;
  logic [7:0]        analog_b;
  logic [7:0]        screen_mask;

  modport source (
    output valid, output status, output axis_one, output axis_two, output axis_three,
    output axis_four, output button_mask, output analog_a, output analog_b,
    output screen_mask, input ready
  );
  modport sink (
    input valid, input status, input axis_one, input axis_two, input axis_three,
    input axis_four, input button_mask, input analog_a, input analog_b,
    input screen_mask, output ready
  );
endinterface

`default_nettype wire

[sv/gpd_collect.sv]
// gpd_collect: header hunt, byte position, running xor and packet byte store
// depends on gpd_pkg
`default_nettype none

module gpd_collect
  import gpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] in_byte,
  output pkt_done_t       done,
  output coll_stat_t      stat
);

  logic [POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       store_r [1:PKT_LEN-2];
  logic             hunting;

  // out-of-range positions count as hunting
  assign hunting = (byte_pos_r == POS_HUNT) || (byte_pos_r >= POS_LIMIT);

  // position and checksum update
  always_comb begin
    byte_pos_nxt = byte_pos_r;
    xor_nxt      = xor_r;
    if (in_fire) begin
      if (hunting) begin
        if (in_byte == HDR_BYTE) begin
          byte_pos_nxt = POS_W'(1);
          xor_nxt      = in_byte;
        end else begin
          byte_pos_nxt = POS_HUNT;
        end
      end else begin
        if (byte_pos_r < POS_SUM) begin
          xor_nxt = xor_r ^ in_byte;
        end
        if (byte_pos_r == POS_LAST) begin
          byte_pos_nxt = POS_HUNT;
        end else begin
          byte_pos_nxt = byte_pos_r + POS_W'(1);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= POS_HUNT;
      xor_r      <= 8'h00;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      xor_r      <= xor_nxt;
    end
  end

  // byte store, one slot per packet position 1..10
  always_ff @(posedge clk) begin
    for (int k = 1; k <= PKT_LEN - 2; k++) begin
      if (in_fire && !hunting && byte_pos_r == POS_W'(k)) begin
        store_r[k] <= in_byte;
      end
    end
  end

  // completed packet view
  always_comb begin
    done.fire       = in_fire && !hunting && (byte_pos_r == POS_LAST);
    done.sum        = xor_r;
    done.check_byte = store_r[PKT_LEN-2];
    done.end_byte   = in_byte;
    for (int k = 0; k < 9; k++) begin
      done.data[k] = store_r[k+1];
    end
  end

  assign stat.last_slot = !hunting && (byte_pos_r == POS_LAST);

endmodule

`default_nettype wire

[sv/gpd_check.sv]
// gpd_check: end marker and checksum test, field decode, result register
// depends on gpd_pkg
`default_nettype none

module gpd_check
  import gpd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  pkt_done_t          done,
  output logic               room,
  gpd_result_if.source       out_chan
);

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic signed [7:0] axis_r [0:3];
  logic [15:0]       button_r;
  logic [7:0]        analog_a_r, analog_b_r, screen_r;

  // result register can take a new request
  assign room = !out_valid_r || out_chan.ready;

  // status, end marker checked first
  always_comb begin
    if (done.end_byte != END_BYTE) begin
      status_nxt = ST_BAD_END;
    end else if ((done.sum ^ SALT_BYTE) != done.check_byte) begin
      status_nxt = ST_BAD_SUM;
    end else begin
      status_nxt = ST_VALID;
    end
  end

  // valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload load
  always_ff @(posedge clk) begin
    if (done.fire) begin
      status_r <= status_nxt;
      for (int k = 0; k < 4; k++) begin
        axis_r[k] <= $signed(done.data[k] - AXIS_BIAS);
      end
      button_r   <= {done.data[5], done.data[4]};
      analog_a_r <= done.data[6];
      analog_b_r <= done.data[7];
      screen_r   <= done.data[8];
    end
  end

  // drive result channel
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = status_r;
  assign out_chan.axis_one    = axis_r[0];
  assign out_chan.axis_two    = axis_r[1];
  assign out_chan.axis_three  = axis_r[2];
  assign out_chan.axis_four   = axis_r[3];
  assign out_chan.button_mask = button_r;
  assign out_chan.analog_a    = analog_a_r;
  assign out_chan.analog_b    = analog_b_r;
  assign out_chan.screen_mask = screen_r;

endmodule

`default_nettype wire

[sv/gamepad_packet_deframer_unit.sv]
// gamepad_packet_deframer_unit: top level, byte collector feeding the packet checker
// depends on gpd_pkg, gpd_ifs, gpd_collect, gpd_check
//
//   channel    dir  carries
//   in_chan    in   rx_byte, one serial byte per request
//   out_chan   out  status plus decoded axes, buttons and screen bits per packet
//
// one byte is taken per cycle; a packet result appears in the cycle after its
// twelfth byte is taken and stays until the sink takes it.
// the only stall point is the twelfth byte: it waits while an earlier result
// still sits unclaimed in the result register; other bytes are always taken.
// synchronous active-low reset returns the collector to header hunting and
// empties the result register; the byte store is not cleared.
`default_nettype none

module gamepad_packet_deframer_unit
  import gpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  gpd_byte_if.sink     in_chan,
  gpd_result_if.source out_chan
);

  pkt_done_t  done;
  coll_stat_t stat;
  logic       room;
  logic       in_fire;

  // completing byte needs a free result register
  assign in_chan.ready = !stat.last_slot || room;
  assign in_fire       = in_chan.valid && in_chan.ready;

  gpd_collect u_collect (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_chan.rx_byte),
    .done    (done),
    .stat    (stat)
  );

  gpd_check u_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .done     (done),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: random and directed byte streams through gamepad_packet_deframer_unit,
// with every decoded packet checked against an in-bench frame decoder
// depends on gpd_pkg, gpd_ifs and the deframer rtl
`timescale 1ns / 100ps

module testbench;
  import gpd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int FRAMED_ITEMS = 500;
  localparam int HOLD_START   = 250;
  localparam int HOLD_LEN     = 160;
  localparam int CALM_FROM    = 500;
  localparam int CALM_TO      = 650;
  localparam int DRAIN_CYCLES = 20;

  // one decoded packet as the result channel carries it
  typedef struct packed {
    status_t     status;
    logic [7:0]  axis_one;
    logic [7:0]  axis_two;
    logic [7:0]  axis_three;
    logic [7:0]  axis_four;
    logic [15:0] button_mask;
    logic [7:0]  analog_a;
    logic [7:0]  analog_b;
    logic [7:0]  screen_mask;
  } decoded_packet_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   mismatches = 0;
  bit   in_taken = 1'b0;
  int   hold_left = 0;

  logic [7:0]      pending_bytes[$];
  decoded_packet_t expected_packets[$];
  decoded_packet_t seen_packet;
  decoded_packet_t want_packet;

  // decoder state mirrored from the block
  logic [3:0] frame_pos = 4'd0;
  logic [7:0] frame_xor = 8'd0;
  logic [7:0] frame_bytes[PKT_LEN];

  gpd_byte_if   in_chan();
  gpd_result_if out_chan();

  gamepad_packet_deframer_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wire calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  // frame decoder: consumes one accepted byte, queues a packet on the twelfth
  task automatic absorb_byte(input logic [7:0] b);
    decoded_packet_t pkt;
    logic [3:0] slot;
    slot = (frame_pos >= PKT_LEN) ? 4'd0 : frame_pos;
    if (slot == 4'd0 && b != HDR_BYTE) begin
      frame_pos = 4'd0;
    end else begin
      if (slot == 4'd0) frame_xor = 8'd0;
      frame_bytes[slot] = b;
      if (slot < PKT_LEN - 2) frame_xor ^= b;
      slot++;
      if (slot < PKT_LEN) begin
        frame_pos = slot;
      end else begin
        frame_pos = 4'd0;
        // end marker outranks the checksum
        if (frame_bytes[PKT_LEN-1] != END_BYTE) pkt.status = ST_BAD_END;
        else if ((frame_xor ^ SALT_BYTE) != frame_bytes[PKT_LEN-2]) pkt.status = ST_BAD_SUM;
        else pkt.status = ST_VALID;
        pkt.axis_one    = frame_bytes[1] - AXIS_BIAS;
        pkt.axis_two    = frame_bytes[2] - AXIS_BIAS;
        pkt.axis_three  = frame_bytes[3] - AXIS_BIAS;
        pkt.axis_four   = frame_bytes[4] - AXIS_BIAS;
        pkt.button_mask = {frame_bytes[6], frame_bytes[5]};
        pkt.analog_a    = frame_bytes[7];
        pkt.analog_b    = frame_bytes[8];
        pkt.screen_mask = frame_bytes[9];
        expected_packets.push_back(pkt);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // header, nine payload bytes, checksum and end marker; either check can be broken
  task automatic add_packet(input logic [7:0] payload[9], input bit break_sum,
                            input bit break_end);
    logic [7:0] sum;
    sum = HDR_BYTE;
    pending_bytes.push_back(HDR_BYTE);
    foreach (payload[i]) begin
      pending_bytes.push_back(payload[i]);
      sum ^= payload[i];
    end
    sum ^= SALT_BYTE;
    pending_bytes.push_back(break_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
    pending_bytes.push_back(break_end ? END_BYTE ^ 8'($urandom_range(255, 1)) : END_BYTE);
  endtask

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // monitor: feeds accepted byte requests to the decoder, checks result requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_chan.valid && in_chan.ready;
      if (in_taken) absorb_byte(in_chan.rx_byte);
      if (out_chan.valid && out_chan.ready) begin
        seen_packet.status      = out_chan.status;
        seen_packet.axis_one    = out_chan.axis_one;
        seen_packet.axis_two    = out_chan.axis_two;
        seen_packet.axis_three  = out_chan.axis_three;
        seen_packet.axis_four   = out_chan.axis_four;
        seen_packet.button_mask = out_chan.button_mask;
        seen_packet.analog_a    = out_chan.analog_a;
        seen_packet.analog_b    = out_chan.analog_b;
        seen_packet.screen_mask = out_chan.screen_mask;
        if (expected_packets.size() == 0) begin
          $error("result with no packet pending: %p", seen_packet);
          mismatches++;
        end else begin
          want_packet = expected_packets.pop_front();
          check_field("status", 16'(want_packet.status), 16'(seen_packet.status));
          check_field("axis_one", 16'(want_packet.axis_one), 16'(seen_packet.axis_one));
          check_field("axis_two", 16'(want_packet.axis_two), 16'(seen_packet.axis_two));
          check_field("axis_three", 16'(want_packet.axis_three),
                      16'(seen_packet.axis_three));
          check_field("axis_four", 16'(want_packet.axis_four), 16'(seen_packet.axis_four));
          check_field("button_mask", want_packet.button_mask, seen_packet.button_mask);
          check_field("analog_a", 16'(want_packet.analog_a), 16'(seen_packet.analog_a));
          check_field("analog_b", 16'(want_packet.analog_b), 16'(seen_packet.analog_b));
          check_field("screen_mask", 16'(want_packet.screen_mask),
                      16'(seen_packet.screen_mask));
        end
      end
    end
  end

  // byte driver: a new request only once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_chan.valid || in_taken)) begin
      if (pending_bytes.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
        in_chan.rx_byte <= pending_bytes.pop_front();
        in_chan.valid   <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result sink: random stalls plus one long hold-off that backs up the input
  always @(negedge clk) begin
    if (cycle_count == HOLD_START) hold_left = HOLD_LEN;
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [7:0] payload[9];
    int framed;
    int pick;
    int n;
    in_chan.valid   = 1'b0;
    in_chan.rx_byte = 8'h00;
    out_chan.ready  = 1'b0;

    // directed: noise extremes, a clean packet carrying extremes and a header byte
    // in its payload, then a packet failing both checks
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFF);
    payload = '{8'h00, 8'hFF, 8'h80, 8'h7F, HDR_BYTE, 8'h00, 8'hFF, 8'h00, 8'hFF};
    add_packet(payload, 1'b0, 1'b0);
    payload = '{8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00, HDR_BYTE};
    add_packet(payload, 1'b1, 1'b1);

    // random: mostly well-formed packets, some broken ones, noise and cut-off frames
    framed = 0;
    while (framed < FRAMED_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        foreach (payload[i]) payload[i] = 8'($urandom_range(255));
        add_packet(payload, (pick >= 70 && pick < 80) || (pick >= 84 && $urandom_range(1)),
                   pick >= 80);
        framed += PKT_LEN;
      end else if (pick < 95) begin
        n = $urandom_range(4, 1);
        repeat (n) pending_bytes.push_back(8'($urandom_range(255)));
      end else begin
        // header then a short run: the next packet's bytes finish this frame
        n = $urandom_range(6, 1);
        pending_bytes.push_back(HDR_BYTE);
        repeat (n) pending_bytes.push_back(8'($urandom_range(255)));
        framed += n + 1;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_chan.valid) @(negedge clk);
    while (expected_packets.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[gamepad_packet_deframer_unit.f]
sv/gpd_pkg.sv
sv/gpd_ifs.sv
sv/gpd_collect.sv
sv/gpd_check.sv
sv/gamepad_packet_deframer_unit.sv
bench/testbench.sv
